[hdl/chull_pkg.sv]
package chull_pkg;

   localparam int MAX_POINTS = 32;
   localparam int COORD_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int CH_DEPTH   = MAX_POINTS + 2;
   localparam int CH_AW      = $clog2(CH_DEPTH);
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int REQ_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((IDX_W + CNT_W + 7) / 8) * 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      point_type        pt;
   } chain_entry_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RK_ADDR,
      ST_RK_HOLD,
      ST_RK_RD,
      ST_RK_CMP,
      ST_HL_ORD,
      ST_HL_IDX,
      ST_HL_PT,
      ST_HL_CHK,
      ST_HL_CMP,
      ST_HL_REFILL,
      ST_EM_SETUP,
      ST_EM_RD,
      ST_EM_WAIT
   } state_type;

endpackage

[hdl/chull_orient.sv]
// Orientation test for the chain: pop the top t (below it b) for new point p
// when (p - t) x (b - t) is at most zero. Products are registered.
module chull_orient
   import chull_pkg::*;
(
   input  logic      clock,
   input  logic      calc,
   input  point_type p,
   input  point_type t,
   input  point_type b,
   output logic      pop
);

   logic signed [DIFF_W-1:0] a, bb, c, d;
   logic signed [PROD_W-1:0] lhs_ff, rhs_ff;

   assign a  = DIFF_W'(p.x) - DIFF_W'(t.x);
   assign bb = DIFF_W'(p.y) - DIFF_W'(t.y);
   assign c  = DIFF_W'(b.x) - DIFF_W'(t.x);
   assign d  = DIFF_W'(b.y) - DIFF_W'(t.y);

   always_ff @(posedge clock) begin
      if (calc) begin
         lhs_ff <= a * d;
         rhs_ff <= bb * c;
      end
   end

   assign pop = (lhs_ff <= rhs_ff);

endmodule

[hdl/convex_hull_2d.sv]
// channel | dir | handshake           | contents
// req     | in  | req_tvalid/tready   | tdata: point_x, point_y; tlast: last_point
// rsp     | out | rsp_tvalid/tready   | tdata: hull_index, hull_count; tlast: hull_last;
//         |     |                     | tuser: overflow
// Points load one per cycle while in ST_LOAD; the tlast transaction closes the set.
// Ranking sort walks the point store, comparing each point with all n points.
// Chain build: two passes over the ranked points, popping the chain top as needed.
// Emission: setup, then read and wait states per vertex, held while rsp stalls.
// Synchronous reset clears control only; no memory clearing pass.
module convex_hull_2d
   import chull_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // point_x, point_y
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // hull_index, hull_count, zero fill
   output logic                  rsp_tlast,
   output logic                  rsp_tuser   // overflow
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0] point_count_ff, point_count_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] rank_ff, rank_in;
   point_type        pi_ff, pi_in;
   point_type        p_ff, p_in;
   logic [IDX_W-1:0] p_idx_ff, p_idx_in;
   chain_entry_type  t_ff, t_in, b_ff, b_in;
   logic [CH_AW-1:0] k_ff, k_in, kmin_ff, kmin_in;
   logic             upper_ff, upper_in;
   point_type        c0_ff, c0_in, c1_ff, c1_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, e_ff, e_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] out_idx_ff, out_idx_in;
   logic [CNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic             out_last_ff, out_last_in, out_ovf_ff, out_ovf_in;

   point_type       store_mem [MAX_POINTS];
   point_type       store_q;
   logic            store_we;
   logic [IDX_W-1:0] store_raddr;

   logic [IDX_W-1:0] order_mem [MAX_POINTS];
   logic [IDX_W-1:0] order_q, order_waddr, order_wdata, order_raddr;
   logic             order_we;

   chain_entry_type  chain_mem [CH_DEPTH];
   chain_entry_type  chain_q, chain_wdata;
   logic [CH_AW-1:0] ch_raddr;
   logic             chain_we;

   logic             req_fire, calc, pop, do_push, beat;
   logic [IDX_W-1:0] rank_next;
   logic [CH_AW-1:0] cnt_raw;

   function automatic logic sorts_first(point_type q, logic [CNT_W-1:0] qi,
                                        point_type r, logic [CNT_W-1:0] ri);
      logic res;
      if (q.x != r.x) res = (q.x < r.x);
      else if (q.y != r.y) res = (q.y > r.y);
      else res = (qi < ri);
      return res;
   endfunction

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_LOAD);
   assign store_we = req_fire && (point_count_ff < CNT_W'(MAX_POINTS));

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[point_count_ff[IDX_W-1:0]] <= {coord_type'(req_tdata[COORD_BITS-1:0]),
                                                 coord_type'(req_tdata[2*COORD_BITS-1:COORD_BITS])};
      end
      store_q <= store_mem[store_raddr];
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[order_waddr] <= order_wdata;
      end
      order_q <= order_mem[order_raddr];
   end

   always_ff @(posedge clock) begin
      if (chain_we) begin
         chain_mem[k_ff] <= chain_wdata;
      end
      chain_q <= chain_mem[ch_raddr];
   end

   chull_orient u_orient (
      .clock (clock),
      .calc  (calc),
      .p     (p_ff),
      .t     (t_ff.pt),
      .b     (b_ff.pt),
      .pop   (pop)
   );

   assign beat = sorts_first(store_q, j_ff, pi_ff, i_ff);
   assign rank_next = rank_ff + IDX_W'(beat);
   assign cnt_raw = k_ff - CH_AW'(1);

   always_comb begin
      state_in = state_ff;
      point_count_in = point_count_ff;
      dropped_in = dropped_ff;
      n_in = n_ff;
      i_in = i_ff;
      j_in = j_ff;
      rank_in = rank_ff;
      pi_in = pi_ff;
      p_in = p_ff;
      p_idx_in = p_idx_ff;
      t_in = t_ff;
      b_in = b_ff;
      k_in = k_ff;
      kmin_in = kmin_ff;
      upper_in = upper_ff;
      c0_in = c0_ff;
      c1_in = c1_ff;
      cnt_in = cnt_ff;
      e_in = e_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_idx_in = out_idx_ff;
      out_cnt_in = out_cnt_ff;
      out_last_in = out_last_ff;
      out_ovf_in = out_ovf_ff;
      store_raddr = j_ff[IDX_W-1:0];
      order_raddr = i_ff[IDX_W-1:0];
      ch_raddr = CH_AW'(e_ff);
      order_we = 1'b0;
      order_waddr = rank_next;
      order_wdata = i_ff[IDX_W-1:0];
      chain_we = 1'b0;
      chain_wdata = {p_idx_ff, p_ff};
      calc = 1'b0;
      do_push = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (store_we) point_count_in = point_count_ff + CNT_W'(1);
               else dropped_in = 1'b1;
               if (req_tlast) begin
                  n_in = store_we ? point_count_ff + CNT_W'(1) : point_count_ff;
                  i_in = '0;
                  state_in = ST_RK_ADDR;
               end
            end
         end
         ST_RK_ADDR: begin
            store_raddr = i_ff[IDX_W-1:0];
            state_in = ST_RK_HOLD;
         end
         ST_RK_HOLD: begin
            pi_in = store_q;
            j_in = '0;
            rank_in = '0;
            state_in = ST_RK_RD;
         end
         ST_RK_RD: begin
            state_in = ST_RK_CMP;
         end
         ST_RK_CMP: begin
            if (j_ff == n_ff - CNT_W'(1)) begin
               order_we = 1'b1;
               i_in = i_ff + CNT_W'(1);
               if (i_ff == n_ff - CNT_W'(1)) begin
                  i_in = '0;
                  k_in = '0;
                  kmin_in = CH_AW'(2);
                  upper_in = 1'b0;
                  state_in = ST_HL_ORD;
               end else begin
                  state_in = ST_RK_ADDR;
               end
            end else begin
               j_in = j_ff + CNT_W'(1);
               rank_in = rank_next;
               state_in = ST_RK_RD;
            end
         end
         ST_HL_ORD: begin
            state_in = ST_HL_IDX;
         end
         ST_HL_IDX: begin
            store_raddr = order_q;
            p_idx_in = order_q;
            state_in = ST_HL_PT;
         end
         ST_HL_PT: begin
            p_in = store_q;
            state_in = ST_HL_CHK;
         end
         ST_HL_CHK: begin
            if (k_ff >= kmin_ff) begin
               calc = 1'b1;
               state_in = ST_HL_CMP;
            end else begin
               do_push = 1'b1;
            end
         end
         ST_HL_CMP: begin
            if (pop) begin
               k_in = k_ff - CH_AW'(1);
               t_in = b_ff;
               // new below-top entry sits just under the new top
               if (k_ff >= CH_AW'(3)) begin
                  ch_raddr = k_ff - CH_AW'(3);
                  state_in = ST_HL_REFILL;
               end else begin
                  state_in = ST_HL_CHK;
               end
            end else begin
               do_push = 1'b1;
            end
         end
         ST_HL_REFILL: begin
            b_in = chain_q;
            state_in = ST_HL_CHK;
         end
         ST_EM_SETUP: begin
            if (n_ff == CNT_W'(1)) cnt_in = CNT_W'(1);
            else if (cnt_raw == CH_AW'(2) && c0_ff == c1_ff) cnt_in = CNT_W'(1);
            else cnt_in = CNT_W'(cnt_raw);
            e_in = '0;
            state_in = ST_EM_RD;
         end
         ST_EM_RD: begin
            state_in = ST_EM_WAIT;
         end
         ST_EM_WAIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_idx_in = chain_q.idx;
               out_cnt_in = cnt_ff;
               out_ovf_in = dropped_ff;
               out_last_in = (e_ff == cnt_ff - CNT_W'(1));
               if (e_ff == cnt_ff - CNT_W'(1)) begin
                  point_count_in = '0;
                  dropped_in = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  e_in = e_ff + CNT_W'(1);
                  state_in = ST_EM_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase

      if (do_push) begin
         chain_we = 1'b1;
         b_in = t_ff;
         t_in = chain_wdata;
         k_in = k_ff + CH_AW'(1);
         if (k_ff == CH_AW'(0)) c0_in = p_ff;
         if (k_ff == CH_AW'(1)) c1_in = p_ff;
         state_in = ST_HL_ORD;
         if (!upper_ff) begin
            if (i_ff == n_ff - CNT_W'(1)) begin
               if (n_ff == CNT_W'(1)) begin
                  state_in = ST_EM_SETUP;
               end else begin
                  upper_in = 1'b1;
                  kmin_in = k_ff + CH_AW'(2);
                  i_in = n_ff - CNT_W'(2);
               end
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
         end else begin
            if (i_ff == '0) state_in = ST_EM_SETUP;
            else i_in = i_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         point_count_ff <= '0;
         dropped_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         point_count_ff <= point_count_in;
         dropped_ff <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      i_ff <= i_in;
      j_ff <= j_in;
      rank_ff <= rank_in;
      pi_ff <= pi_in;
      p_ff <= p_in;
      p_idx_ff <= p_idx_in;
      t_ff <= t_in;
      b_ff <= b_in;
      k_ff <= k_in;
      kmin_ff <= kmin_in;
      upper_ff <= upper_in;
      c0_ff <= c0_in;
      c1_ff <= c1_in;
      cnt_ff <= cnt_in;
      e_ff <= e_in;
      out_idx_ff <= out_idx_in;
      out_cnt_ff <= out_cnt_in;
      out_last_ff <= out_last_in;
      out_ovf_ff <= out_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_DATA_W'({out_cnt_ff, out_idx_ff});
   assign rsp_tlast = out_last_ff;
   assign rsp_tuser = out_ovf_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      point_count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond capacity");
   a_chain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HL_CHK || state_ff == ST_HL_CMP) |-> k_ff <= CH_AW'(MAX_POINTS + 1))
      else $error("chain top beyond depth");
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EM_RD || state_ff == ST_EM_WAIT) |-> e_ff < cnt_ff)
      else $error("emission index past hull count");
   a_pop_keeps_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HL_CMP) |-> k_ff >= kmin_ff)
      else $error("orientation test below chain floor");
`endif

endmodule

[tb/sv/convex_hull_2d_tb.sv]
`timescale 1ns / 100ps

module convex_hull_2d_tb;
   import chull_pkg::*;

   typedef struct {
      logic [IDX_W-1:0] idx;
      logic             last;
      logic [CNT_W-1:0] count;
      logic             ovf;
   } vertex_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // point_x, point_y
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // hull_index, hull_count, zero fill
   logic                  rsp_tlast;
   logic                  rsp_tuser;   // overflow

   // predictor state: the set currently being collected
   coord_type  set_x[MAX_POINTS];
   coord_type  set_y[MAX_POINTS];
   int         set_size;
   bit         set_dropped;
   vertex_type hull_queue[$];
   int         error_count;
   int         burst_left;
   bit         hold_rsp;

   convex_hull_2d u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("convex_hull_2d_tb failed");
      $finish;
   end

   function automatic bit sorts_first(int a, int b);
      if (set_x[a] != set_x[b]) return set_x[a] < set_x[b];
      if (set_y[a] != set_y[b]) return set_y[a] > set_y[b];
      return a < b;
   endfunction

   // pop when cross(b->t, t->p) turns clockwise or is collinear
   function automatic bit drops_top(int b, int t, int p);
      longint dx_p, dy_p, dx_b, dy_b;
      dx_p = longint'(set_x[p]) - set_x[t];
      dy_p = longint'(set_y[p]) - set_y[t];
      dx_b = longint'(set_x[b]) - set_x[t];
      dy_b = longint'(set_y[b]) - set_y[t];
      return dx_p * dy_b <= dy_p * dx_b;
   endfunction

   task automatic close_set();
      int ord[MAX_POINTS];
      int hull[MAX_POINTS + 2];
      int n, k, lim, cnt, v, j;
      vertex_type e;
      n = set_size;
      k = 0;
      for (int i = 0; i < n; i++) begin
         v = i;
         j = i;
         while (j > 0 && sorts_first(v, ord[j-1])) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = v;
      end
      if (n <= 1) begin
         hull[0] = ord[0];
         cnt = 1;
      end else begin
         for (int i = 0; i < n; i++) begin
            while (k >= 2 && drops_top(hull[k-2], hull[k-1], ord[i])) k--;
            hull[k++] = ord[i];
         end
         lim = k + 1;
         for (int i = n - 2; i >= 0; i--) begin
            while (k >= lim && drops_top(hull[k-2], hull[k-1], ord[i])) k--;
            hull[k++] = ord[i];
         end
         cnt = k - 1;
         if (cnt == 2 && set_x[hull[0]] == set_x[hull[1]] &&
             set_y[hull[0]] == set_y[hull[1]])
            cnt = 1;
      end
      for (int i = 0; i < cnt; i++) begin
         e.idx   = IDX_W'(hull[i]);
         e.last  = (i == cnt - 1);
         e.count = CNT_W'(cnt);
         e.ovf   = set_dropped;
         hull_queue.push_back(e);
      end
      set_size    = 0;
      set_dropped = 0;
   endtask

   task automatic send_point(input coord_type x, input coord_type y, input bit last);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) == 0) burst_left = 1000;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (set_size < MAX_POINTS) begin
         set_x[set_size] = x;
         set_y[set_size] = y;
         set_size++;
      end else begin
         set_dropped = 1;
      end
      if (last) close_set();
   endtask

   task automatic finish_send();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
   endtask

   task automatic wait_drained();
      finish_send();
      while (hull_queue.size() != 0) @(posedge clock);
   endtask

   // result check
   initial begin
      vertex_type e;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (hull_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected transaction idx=%0d", rsp_tdata[IDX_W-1:0]);
            end else begin
               e = hull_queue.pop_front();
               if (rsp_tdata[IDX_W-1:0] !== e.idx ||
                   rsp_tdata[IDX_W +: CNT_W] !== e.count ||
                   rsp_tdata[RSP_DATA_W-1:IDX_W+CNT_W] !== '0 ||
                   rsp_tlast !== e.last || rsp_tuser !== e.ovf) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"mismatch: exp idx=%0d cnt=%0d last=%0b ovf=%0b,",
                               " got idx=%0d cnt=%0d last=%0b ovf=%0b"},
                              e.idx, e.count, e.last, e.ovf,
                              rsp_tdata[IDX_W-1:0], rsp_tdata[IDX_W +: CNT_W],
                              rsp_tlast, rsp_tuser);
               end
            end
         end
      end
   end

   // receiver stall pattern: alternating runs of free flow and random stalls
   initial begin
      int run;
      rsp_tready = 1'b0;
      forever begin
         run = $urandom_range(1, 40);
         hold_rsp = ~hold_rsp;
         repeat (run) begin
            @(posedge clock);
            rsp_tready <= hold_rsp ? ($urandom_range(0, 2) == 0) : 1'b1;
         end
      end
   end

   function automatic coord_type rand_coord(int span);
      case ($urandom_range(0, 5))
         0:       return coord_type'($urandom);
         1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return coord_type'(int'($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   task automatic test_directed();
      send_point(16'sd5, -16'sd3, 1);                       // single point
      send_point(16'sd7, 16'sd7, 0);                        // all identical
      send_point(16'sd7, 16'sd7, 0);
      send_point(16'sd7, 16'sd7, 1);
      send_point(16'sd0, 16'sd0, 0);                        // collinear
      send_point(16'sd2, 16'sd2, 0);
      send_point(16'sd1, 16'sd1, 0);
      send_point(16'sd3, 16'sd3, 1);
      send_point(16'sh8000, 16'sh8000, 0);                  // coordinate extremes
      send_point(16'sh7fff, 16'sh8000, 0);
      send_point(16'sh7fff, 16'sh7fff, 0);
      send_point(16'sh8000, 16'sh7fff, 0);
      send_point(16'sd0, 16'sd0, 1);
      send_point(16'sd4, 16'sd0, 0);                        // vertical ties
      send_point(16'sd4, 16'sd9, 0);
      send_point(-16'sd4, 16'sd1, 1);
      wait_drained();
   endtask

   task automatic test_capacity();
      for (int i = 0; i < MAX_POINTS + 3; i++)
         send_point(rand_coord(200), rand_coord(200), i == MAX_POINTS + 2);
      for (int i = 0; i < MAX_POINTS + 1; i++)
         send_point(coord_type'(i * 3), coord_type'(i * i), i == MAX_POINTS);
      wait_drained();
   endtask

   task automatic test_random();
      int sent, n, span;
      sent = 0;
      while (sent < 260) begin
         n    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 8);
         span = ($urandom_range(0, 2) == 0) ? 3 : 30000;
         for (int i = 0; i < n; i++)
            send_point(rand_coord(span), rand_coord(span), i == n - 1);
         sent += n;
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      int guard;
      set_size    = 0;
      set_dropped = 0;
      burst_left  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity();
      test_random();
      guard = 0;
      while (hull_queue.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (200) @(posedge clock);
      if (error_count == 0 && hull_queue.size() == 0)
         $display("convex_hull_2d_tb passed");
      else
         $display("convex_hull_2d_tb failed");
      $finish;
   end

endmodule
